/* src/omp_pkg.sv */
// Shared constants and types for the occupancy max pyramid.
package omp_pkg;

    localparam int MaxWidth  = 512;
    localparam int MaxHeight = 512;
    localparam int MaxLevels = 8;

    localparam int ColW  = $clog2(MaxWidth);
    localparam int RowW  = $clog2(MaxHeight);
    localparam int AddrW = ColW + RowW;
    localparam int LvlW  = 3;
    localparam int DimW  = 10;

    typedef enum logic [2:0] {
        CFG_MAP_WIDTH   = 3'd0,
        CFG_MAP_HEIGHT  = 3'd1,
        CFG_LEVEL_COUNT = 3'd2,
        CFG_NEGATE_MODE = 3'd3,
        CFG_PIXEL_MAX   = 3'd4
    } cfg_idx_t;

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic       CMD_READ   = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ADR = 2'd1;
    localparam logic [1:0] ST_BAD_LVL = 2'd2;

    typedef struct packed {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
        logic            wr;
        logic [7:0]      wdata;
        logic            last;
    } mem_op_t;

endpackage

/* src/omp_if.sv */
// Valid/ready channel carrying a payload.
interface omp_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/occupancy_max_pyramid_top.sv */
// Top level of the occupancy max pyramid.
//   channel | dir | payload
//   req     | in  | cmd, col, row, level, raw_pixel
//   rsp     | out | cell_value, status
// One item at a time. A write runs the 9-step divider; a read issues one
// memory read per cell of the clipped window. A bad address or level
// goes straight to the response. Reset sets control and the config
// registers to defaults, not the memory. Req waits while rsp is stalled.
module occupancy_max_pyramid_top
    import omp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    omp_if.sink        req,
    omp_if.source      rsp
);
    typedef enum logic [2:0] {S_IDLE, S_CONV, S_WALK, S_DRAIN, S_RESP} state_t;
    state_t state_reg;

    logic [9:0] width_reg, height_reg;
    logic [3:0] levels_reg;
    logic       negate_reg;
    logic [7:0] pmax_reg;

    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [7:0]      best_reg, value_reg;
    logic [1:0]      status_reg;
    logic            rvalid_reg;

    logic [DimW:0] w, h;
    logic [3:0]    lv;
    logic          take;
    logic          bad_adr, bad_lvl;

    logic       conv_done;
    logic [7:0] conv_occ;
    logic       walk_active;
    mem_op_t    walk_op;
    logic       mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [7:0] mem_rdata;

    assign w  = (width_reg  > 10'(MaxWidth))  ? (DimW+1)'(MaxWidth)  : (DimW+1)'(width_reg);
    assign h  = (height_reg > 10'(MaxHeight)) ? (DimW+1)'(MaxHeight) : (DimW+1)'(height_reg);
    assign lv = (levels_reg == 4'd0) ? 4'd1 :
                (levels_reg > 4'(MaxLevels)) ? 4'(MaxLevels) : levels_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign take = req.valid && req.ready;
    assign bad_adr = ((DimW+1)'(req.data.col) >= w) || ((DimW+1)'(req.data.row) >= h);
    assign bad_lvl = {1'b0, req.data.level} >= lv;

    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.data.cell_value = value_reg;
    assign rsp.data.status = status_reg;

    omp_conv u_conv (
        .clk(clk), .rst_n(rst_n),
        .start(take && !bad_adr && req.data.cmd == CMD_WRITE),
        .raw(req.data.raw_pixel), .pmax(pmax_reg), .negate(negate_reg),
        .done(conv_done), .occ(conv_occ)
    );

    omp_walk u_walk (
        .clk(clk), .rst_n(rst_n),
        .start(take && !bad_adr && req.data.cmd == CMD_READ && !bad_lvl),
        .col(req.data.col), .row(req.data.row), .level(req.data.level),
        .w(w), .h(h), .active(walk_active), .op(walk_op)
    );

    assign mem_we = (state_reg == S_CONV) && conv_done;
    assign mem_addr = mem_we ? {row_reg, col_reg} : {walk_op.row, walk_op.col};

    omp_ram u_ram (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(conv_occ), .rdata(mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 10'd512;
            height_reg <= 10'd512;
            levels_reg <= 4'd1;
            negate_reg <= 1'b0;
            pmax_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:   width_reg <= cfg_data;
                CFG_MAP_HEIGHT:  height_reg <= cfg_data;
                CFG_LEVEL_COUNT: levels_reg <= cfg_data[3:0];
                CFG_NEGATE_MODE: negate_reg <= cfg_data[0];
                CFG_PIXEL_MAX:   pmax_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= (state_reg == S_WALK) && walk_active;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        col_reg <= req.data.col;
                        row_reg <= req.data.row;
                        best_reg <= 8'd0;
                        value_reg <= 8'd0;
                        if (bad_adr)
                        begin
                            status_reg <= ST_BAD_ADR;
                            state_reg <= S_RESP;
                        end
                        else if (req.data.cmd == CMD_WRITE)
                        begin
                            status_reg <= ST_OK;
                            state_reg <= S_CONV;
                        end
                        else if (bad_lvl)
                        begin
                            status_reg <= ST_BAD_LVL;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        value_reg <= conv_occ;
                        state_reg <= S_RESP;
                    end
                end
                S_WALK:
                begin
                    if (walk_active && walk_op.last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    if (rvalid_reg && mem_rdata > best_reg)
                    begin
                        best_reg <= mem_rdata;
                    end
                end
                S_DRAIN:
                begin
                    value_reg <= (mem_rdata > best_reg) ? mem_rdata : best_reg;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/omp_ram.sv */
// Single-port occupancy memory with registered read data.
module omp_ram
    import omp_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);
    logic [7:0] mem [0:(1<<AddrW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* src/omp_conv.sv */
// Raw pixel to occupancy: (510*n + m) / (2m), sequential restoring divider.
module omp_conv
    import omp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] raw,
    input  logic [7:0] pmax,
    input  logic       negate,
    output logic       done,
    output logic [7:0] occ
);
    logic [7:0]  m;
    logic [7:0]  p;
    logic [7:0]  n;
    logic [16:0] num;
    logic [16:0] rem_reg, rem_next;
    logic [8:0]  den_reg;
    logic [8:0]  q_reg, q_next;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [17:0] trial;

    assign m   = (pmax == 8'd0) ? 8'd1 : pmax;
    assign p   = (raw > m) ? m : raw;
    assign n   = negate ? p : (m - p);
    assign num = 17'(n * 9'd510) + 17'(m);

    // 9 quotient bits, one per cycle
    always_comb
    begin
        trial = {1'b0, rem_reg} - ({9'd0, den_reg} << cnt_reg);
        rem_next = rem_reg;
        q_next = q_reg;
        if (!trial[17])
        begin
            rem_next = trial[16:0];
            q_next = q_reg | (9'd1 << cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg <= num;
                den_reg <= {m, 1'b0};
                q_reg <= '0;
                cnt_reg <= 4'd8;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg <= q_next;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    assign occ = q_reg[8] ? 8'hFF : q_reg[7:0];
endmodule

/* src/omp_walk.sv */
// Window address walker: issues cells row by row, clipped at the map edge.
module omp_walk
    import omp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [ColW-1:0] col,
    input  logic [RowW-1:0] row,
    input  logic [LvlW-1:0] level,
    input  logic [DimW:0]   w,
    input  logic [DimW:0]   h,
    output logic            active,
    output mem_op_t         op
);
    logic [ColW-1:0] c0_reg, c_reg;
    logic [RowW-1:0] r_reg;
    logic [DimW:0]   cend_reg, rend_reg;
    logic [DimW:0]   cend, rend;
    logic            busy_reg;
    logic            col_last, row_last;

    always_comb
    begin
        cend = (DimW+1)'(col) + ((DimW+1)'(1) << level);
        rend = (DimW+1)'(row) + ((DimW+1)'(1) << level);
        if (cend > w) cend = w;
        if (rend > h) rend = h;
    end

    assign col_last = ((DimW+1)'(c_reg) + 1'b1) >= cend_reg;
    assign row_last = ((DimW+1)'(r_reg) + 1'b1) >= rend_reg;
    assign active = busy_reg;
    assign op = '{col: c_reg, row: r_reg, wr: 1'b0, wdata: 8'd0,
                  last: col_last && row_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            c0_reg <= col;
            c_reg <= col;
            r_reg <= row;
            cend_reg <= cend;
            rend_reg <= rend;
        end
        else if (busy_reg)
        begin
            if (col_last)
            begin
                c_reg <= c0_reg;
                r_reg <= r_reg + 1'b1;
                if (row_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end
endmodule

/* dv/tb_occupancy_max_pyramid_top.sv */
// Testbench for occupancy_max_pyramid_top: random and directed map writes and window-max reads.
module tb_occupancy_max_pyramid_top;
    import omp_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic [8:0] col;
        logic [8:0] row;
        logic [2:0] level;
        logic [7:0] raw_pixel;
    } req_t;

    typedef struct packed {
        logic [7:0] cell_value;
        logic [1:0] status;
    } rsp_t;

    localparam int StallLimit = 100000;
    localparam int HoldCycles = 300;

    class occupancy_scoreboard;
        logic [7:0] occ_mem [MaxWidth*MaxHeight];
        bit         written [MaxWidth*MaxHeight];
        int unsigned map_width  = 512;
        int unsigned map_height = 512;
        int unsigned level_count = 1;
        int unsigned negate_mode = 0;
        int unsigned pixel_max  = 255;
        rsp_t        expected_q [$];
        int          errors = 0;

        function int unsigned eff_w();
            return map_width > MaxWidth ? MaxWidth : map_width;
        endfunction

        function int unsigned eff_h();
            return map_height > MaxHeight ? MaxHeight : map_height;
        endfunction

        function int unsigned eff_levels();
            int unsigned n;
            n = level_count;
            if (n < 1) n = 1;
            if (n > MaxLevels) n = MaxLevels;
            return n;
        endfunction

        function void set_reg(cfg_idx_t idx, int unsigned v);
            case (idx)
                CFG_MAP_WIDTH:   map_width   = v & 10'h3ff;
                CFG_MAP_HEIGHT:  map_height  = v & 10'h3ff;
                CFG_LEVEL_COUNT: level_count = v & 4'hf;
                CFG_NEGATE_MODE: negate_mode = v & 1;
                CFG_PIXEL_MAX:   pixel_max   = v & 8'hff;
                default: ;
            endcase
        endfunction

        function int unsigned occupancy(int unsigned raw);
            int unsigned m, p, n, occ;
            m = pixel_max == 0 ? 1 : pixel_max;
            p = raw > m ? m : raw;
            n = negate_mode ? p : m - p;
            occ = (510 * n + m) / (2 * m);
            return occ > 255 ? 255 : occ;
        endfunction

        // Would this read touch a cell never written?
        function bit window_unsafe(req_t it);
            int unsigned side, w, h;
            w = eff_w();
            h = eff_h();
            if (it.cmd != CMD_READ || it.col >= w || it.row >= h || it.level >= eff_levels())
                return 0;
            side = 1 << it.level;
            for (int unsigned dy = 0; dy < side && it.row + dy < h; dy++)
                for (int unsigned dx = 0; dx < side && it.col + dx < w; dx++)
                    if (!written[(it.row + dy) * MaxWidth + it.col + dx]) return 1;
            return 0;
        endfunction

        function void note_input(req_t it);
            rsp_t        r;
            int unsigned side, w, h, best, a;
            w = eff_w();
            h = eff_h();
            r.cell_value = 0;
            r.status = ST_OK;
            if (it.col >= w || it.row >= h) begin
                r.status = ST_BAD_ADR;
            end else if (it.cmd == CMD_WRITE) begin
                a = it.row * MaxWidth + it.col;
                r.cell_value = 8'(occupancy(it.raw_pixel));
                occ_mem[a] = r.cell_value;
                written[a] = 1;
            end else if (it.level >= eff_levels()) begin
                r.status = ST_BAD_LVL;
            end else begin
                side = 1 << it.level;
                best = 0;
                for (int unsigned dy = 0; dy < side && it.row + dy < h; dy++)
                    for (int unsigned dx = 0; dx < side && it.col + dx < w; dx++) begin
                        a = (it.row + dy) * MaxWidth + it.col + dx;
                        if (occ_mem[a] > best) best = occ_mem[a];
                    end
                r.cell_value = 8'(best);
            end
            expected_q = {expected_q, r};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR: %s", msg);
        endtask

        task check(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat value=%0d status=%0d",
                                 got.cell_value, got.status));
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.cell_value !== e.cell_value)
                report($sformatf("cell_value %0d, expected %0d", got.cell_value, e.cell_value));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;

    omp_if #(.payload_t(req_t)) req_ch ();
    omp_if #(.payload_t(rsp_t)) rsp_ch ();

    occupancy_max_pyramid_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    occupancy_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_req_cnt = 0;
    int          hold_ack_cnt = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.data);
        if (hold_req_cnt != hold_ack_cnt)
        begin
            hold_ack_cnt = hold_req_cnt;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("occupancy_max_pyramid_top: mismatch");
            $finish;
        end
    end

    task send_item(req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_input(it);
    endtask

    task send_fields(logic cmd, int unsigned col, int unsigned row, int unsigned level,
                     int unsigned raw);
        req_t it;
        it.cmd = cmd;
        it.col = 9'(col);
        it.row = 9'(row);
        it.level = 3'(level);
        it.raw_pixel = 8'(raw);
        send_item(it);
    endtask

    task drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task write_reg(cfg_idx_t idx, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 10'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Focus box: bottom-right corner of the map, at most 12 by 12 cells.
    task run_phase(int unsigned w, int unsigned h, int unsigned lv, int unsigned ng,
                   int unsigned pm, int unsigned mode, int unsigned n_rand, bit pressure);
        int unsigned ew, eh, fx, fy, el;
        req_t        it;
        drain();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_LEVEL_COUNT, lv);
        write_reg(CFG_NEGATE_MODE, ng);
        write_reg(CFG_PIXEL_MAX, pm);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        ew = sb.eff_w();
        eh = sb.eff_h();
        el = sb.eff_levels();
        fx = ew > 12 ? ew - 12 : 0;
        fy = eh > 12 ? eh - 12 : 0;
        if (ew > 0 && eh > 0)
            for (int unsigned y = fy; y < eh; y++)
                for (int unsigned x = fx; x < ew; x++)
                    send_fields(CMD_WRITE, x, y, $urandom_range(7), $urandom_range(255));
        for (int i = 0; i < n_rand; i++)
        begin
            if (pressure && i == n_rand / 2) hold_req_cnt++;
            it = 30'($urandom());
            if ($urandom_range(99) >= 10 && ew > 0 && eh > 0)
            begin
                it.col = 9'($urandom_range(ew - 1, fx));
                it.row = 9'($urandom_range(eh - 1, fy));
                it.cmd = ($urandom_range(99) < 55) ? CMD_READ : CMD_WRITE;
                if ($urandom_range(99) < 80) it.level = 3'($urandom_range(el - 1));
            end
            if (sb.window_unsafe(it)) it.cmd = CMD_WRITE;
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAP_WIDTH;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset, corner cells, out-of-range levels.
        for (int unsigned y = 500; y < 512; y++)
            for (int unsigned x = 500; x < 512; x++)
                send_fields(CMD_WRITE, x, y, 0, $urandom_range(255));
        send_fields(CMD_WRITE, 511, 511, 7, 0);
        send_fields(CMD_READ, 511, 511, 0, 0);
        send_fields(CMD_WRITE, 511, 511, 0, 255);
        send_fields(CMD_READ, 511, 511, 0, 255);
        send_fields(CMD_READ, 511, 511, 1, 0);
        send_fields(CMD_READ, 500, 500, 7, 0);
        send_fields(CMD_WRITE, 0, 0, 0, 128);
        send_fields(CMD_READ, 0, 0, 0, 0);

        run_phase(8, 8, 4, 1, 100, 0, 40, 1);
        send_fields(CMD_WRITE, 3, 3, 0, 200);
        send_fields(CMD_READ, 0, 0, 3, 0);
        send_fields(CMD_READ, 0, 0, 7, 0);
        send_fields(CMD_READ, 8, 0, 0, 0);
        send_fields(CMD_WRITE, 0, 8, 0, 9);
        run_phase(1, 1, 15, 0, 1, 1, 25, 0);
        run_phase(16, 5, 8, 0, 37, 2, 40, 0);
        run_phase(0, 7, 0, 1, 0, 3, 15, 0);
        run_phase(1000, 1023, 8, 1, 255, 0, 40, 0);
        run_phase(512, 512, 8, 0, 1, 3, 35, 0);
        run_phase(7, 512, 3, 1, 254, 1, 30, 0);
        run_phase(512, 3, 6, 0, 128, 2, 35, 0);
        run_phase(12, 12, 8, 1, 200, 0, 40, 1);
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("occupancy_max_pyramid_top: match");
        else
            $display("occupancy_max_pyramid_top: mismatch");
        $finish;
    end
endmodule
